// File: rtl/tun_pkg.sv
package tun_pkg;

  localparam int COORD_WIDTH      = 24;
  localparam int NORMAL_FRAC_BITS = 30;

  // edge difference, product and normalize widths
  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW;
  localparam int LZW = $clog2(PW);
  localparam int MBW = 31;
  localparam int SQW = 2 * MBW;
  localparam int SW  = 64;
  localparam int LW  = 32;
  localparam int RW  = 35;
  localparam int SQ_STEPS = SW / 2;
  localparam int NW  = NORMAL_FRAC_BITS + 32;
  localparam int QW  = NORMAL_FRAC_BITS + 1;
  localparam int OW  = 32;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] a_z;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] b_z;
    logic signed [COORD_WIDTH-1:0] c_x;
    logic signed [COORD_WIDTH-1:0] c_y;
    logic signed [COORD_WIDTH-1:0] c_z;
  } face_t;

  typedef struct packed {
    logic [2:0][MBW-1:0] m;
    logic [2:0]          neg;
    logic                degen;
  } norm_t;

  typedef struct packed {
    logic [SW-1:0] s;
    norm_t         norm;
  } sum_t;

  typedef struct packed {
    logic [SW-1:0] s;
    logic [RW-1:0] rem;
    logic [LW-1:0] root;
    norm_t         norm;
  } sq_stage_t;

  typedef struct packed {
    logic [LW-1:0] len;
    norm_t         norm;
  } root_t;

  typedef struct packed {
    logic [2:0][LW-1:0] rem;
    logic [2:0][QW-1:0] low;
    logic [LW-1:0]      len;
    logic [2:0]         neg;
    logic               degen;
  } dv_stage_t;

  typedef struct packed {
    logic signed [OW-1:0] normal_x;
    logic signed [OW-1:0] normal_y;
    logic signed [OW-1:0] normal_z;
    logic                 degenerate;
  } result_t;

endpackage

// File: rtl/tun_if.sv
interface tun_in_if;
  logic valid;
  logic ready;
  logic signed [tun_pkg::COORD_WIDTH-1:0] a_x;
  logic signed [tun_pkg::COORD_WIDTH-1:0] a_y;
  logic signed [tun_pkg::COORD_WIDTH-1:0] a_z;
  logic signed [tun_pkg::COORD_WIDTH-1:0] b_x;
  logic signed [tun_pkg::COORD_WIDTH-1:0] b_y;
  logic signed [tun_pkg::COORD_WIDTH-1:0] b_z;
  logic signed [tun_pkg::COORD_WIDTH-1:0] c_x;
  logic signed [tun_pkg::COORD_WIDTH-1:0] c_y;
  logic signed [tun_pkg::COORD_WIDTH-1:0] c_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tun_out_if;
  logic valid;
  logic ready;
  logic signed [tun_pkg::OW-1:0] normal_x;
  logic signed [tun_pkg::OW-1:0] normal_y;
  logic signed [tun_pkg::OW-1:0] normal_z;
  logic degenerate;
  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// File: rtl/triangle_unit_normal.sv
// channel  dir  payload                                  transfer
// face     in   a_x..c_z, COORD_WIDTH bits signed each   valid & ready
// result   out  normal_x/y/z 32 bits signed, degenerate  valid & ready
//
// one face per cycle unless stalled; pipeline (7 front stages, 32 root stages,
// 1 divide setup, NORMAL_FRAC_BITS+1 divide stages, 1 output register)
// the root and divide pipelines resolve one bit per stage
// rst clears all valid bits; payload registers are not reset
// a stall freezes the whole pipeline; face.ready follows the output slot
module triangle_unit_normal (
  input logic       clk,
  input logic       rst,
  tun_in_if.sink    face,
  tun_out_if.source result
);

  // pipeline advances when the output slot is empty or being taken
  logic en;

  logic              f_valid;
  tun_pkg::sum_t     f_data;
  logic              s_valid;
  tun_pkg::root_t    s_data;
  logic              d_valid;
  tun_pkg::result_t  d_data;
  tun_pkg::face_t    face_data;

  assign en         = !d_valid || result.ready;
  assign face.ready = en;

  // gather the vertex fields into one word
  assign face_data = '{a_x: face.a_x, a_y: face.a_y, a_z: face.a_z,
                       b_x: face.b_x, b_y: face.b_y, b_z: face.b_z,
                       c_x: face.c_x, c_y: face.c_y, c_z: face.c_z};

  // edges, cross product, block scaling, sum of squares
  tun_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (face.valid),
    .face      (face_data),
    .out_valid (f_valid),
    .out_data  (f_data)
  );

  // vector length
  tun_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_data   (f_data),
    .out_valid (s_valid),
    .out_data  (s_data)
  );

  // rounded component / length, sign, degenerate override
  tun_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .in_data   (s_data),
    .out_valid (d_valid),
    .out_data  (d_data)
  );

  assign result.valid      = d_valid;
  assign result.normal_x   = d_data.normal_x;
  assign result.normal_y   = d_data.normal_y;
  assign result.normal_z   = d_data.normal_z;
  assign result.degenerate = d_data.degenerate;

endmodule

// File: rtl/tun_front.sv
module tun_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  tun_pkg::face_t  face,
  output logic            out_valid,
  output tun_pkg::sum_t   out_data
);

  localparam int DW  = tun_pkg::DW;
  localparam int PW  = tun_pkg::PW;
  localparam int LZW = tun_pkg::LZW;
  localparam int MBW = tun_pkg::MBW;
  localparam int SQW = tun_pkg::SQW;
  localparam int SW  = tun_pkg::SW;
  localparam int NRW = PW + MBW;

  logic [6:0] vld;

  logic signed [DW-1:0] u [3];
  logic signed [DW-1:0] v [3];
  logic signed [PW-1:0] pr [6];
  logic [PW-1:0]        mag3 [3];
  logic [2:0]           neg3;
  logic [PW-1:0]        mag4 [3];
  logic [2:0]           neg4;
  logic [LZW-1:0]       lz4;
  logic                 degen4;
  tun_pkg::norm_t       n5;
  tun_pkg::norm_t       n6;
  logic [SQW-1:0]       sq6 [3];

  logic signed [PW:0]   xc [3];
  logic [PW-1:0]        or_all;
  logic [LZW-1:0]       lz;
  logic [NRW-1:0]       sh [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  // edge vectors a-b and b-c
  always_ff @(posedge clk) begin
    if (en) begin
      u[0] <= DW'(face.a_x) - DW'(face.b_x);
      u[1] <= DW'(face.a_y) - DW'(face.b_y);
      u[2] <= DW'(face.a_z) - DW'(face.b_z);
      v[0] <= DW'(face.b_x) - DW'(face.c_x);
      v[1] <= DW'(face.b_y) - DW'(face.c_y);
      v[2] <= DW'(face.b_z) - DW'(face.c_z);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr[0] <= PW'(u[1]) * PW'(v[2]);
      pr[1] <= PW'(u[2]) * PW'(v[1]);
      pr[2] <= PW'(u[2]) * PW'(v[0]);
      pr[3] <= PW'(u[0]) * PW'(v[2]);
      pr[4] <= PW'(u[0]) * PW'(v[1]);
      pr[5] <= PW'(u[1]) * PW'(v[0]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xc[i] = (PW+1)'(pr[2*i]) - (PW+1)'(pr[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg3[i] <= xc[i][PW];
        mag3[i] <= xc[i][PW] ? PW'(-xc[i]) : PW'(xc[i]);
      end
    end
  end

  // leading zero count of the largest magnitude
  always_comb begin
    or_all = mag3[0] | mag3[1] | mag3[2];
    lz = '0;
    for (int i = 0; i < PW; i++) begin
      if (or_all[i]) lz = LZW'(PW - 1 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag4   <= mag3;
      neg4   <= neg3;
      lz4    <= lz;
      degen4 <= (or_all == '0);
    end
  end

  // block scaling: largest magnitude lands in [2^30, 2^31)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = {mag4[i], {MBW{1'b0}}} << lz4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n5.m[i] <= sh[i][NRW-1 -: MBW];
      end
      n5.neg   <= neg4;
      n5.degen <= degen4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq6[i] <= SQW'(n5.m[i]) * SQW'(n5.m[i]);
      end
      n6 <= n5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.s    <= SW'(sq6[0]) + SW'(sq6[1]) + SW'(sq6[2]);
      out_data.norm <= n6;
    end
  end

  assign out_valid = vld[6];

endmodule

// File: rtl/tun_sqrt.sv
module tun_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  tun_pkg::sum_t  in_data,
  output logic           out_valid,
  output tun_pkg::root_t out_data
);

  localparam int N  = tun_pkg::SQ_STEPS;
  localparam int RW = tun_pkg::RW;
  localparam int LW = tun_pkg::LW;
  localparam int SW = tun_pkg::SW;

  logic [N:0]          vld;
  tun_pkg::sq_stage_t  st [N+1];

  assign vld[0]     = in_valid;
  assign st[0].s    = in_data.s;
  assign st[0].rem  = '0;
  assign st[0].root = '0;
  assign st[0].norm = in_data.norm;

  // one root bit per stage, restoring
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [RW-1:0] rem2;
    logic [RW-1:0] trial;
    always_comb begin
      rem2  = {st[k].rem[RW-3:0], st[k].s[SW-1 -: 2]};
      trial = RW'({st[k].root, 2'b01});
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1].s    <= st[k].s << 2;
        st[k+1].norm <= st[k].norm;
        if (rem2 >= trial) begin
          st[k+1].rem  <= rem2 - trial;
          st[k+1].root <= {st[k].root[LW-2:0], 1'b1};
        end else begin
          st[k+1].rem  <= rem2;
          st[k+1].root <= {st[k].root[LW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid     = vld[N];
  assign out_data.len  = st[N].root;
  assign out_data.norm = st[N].norm;

endmodule

// File: rtl/tun_div.sv
module tun_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  tun_pkg::root_t   in_data,
  output logic             out_valid,
  output tun_pkg::result_t out_data
);

  localparam int QW  = tun_pkg::QW;
  localparam int NW  = tun_pkg::NW;
  localparam int LW  = tun_pkg::LW;
  localparam int OW  = tun_pkg::OW;
  localparam int NFB = tun_pkg::NORMAL_FRAC_BITS;

  logic [QW+1:0]       vld;
  tun_pkg::dv_stage_t  st [QW+1];
  logic [NW-1:0]       num [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (NW'(in_data.norm.m[i]) << NFB) + NW'(in_data.len >> 1);
    end
  end

  assign vld[0] = in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[1] <= 1'b0;
    end else if (en) begin
      vld[1] <= vld[0];
    end
  end

  // upper numerator bits stay below the length for a non-degenerate face
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        st[0].rem[i] <= LW'(num[i][NW-1:QW]);
        st[0].low[i] <= num[i][QW-1:0];
      end
      st[0].len   <= in_data.len;
      st[0].neg   <= in_data.norm.neg;
      st[0].degen <= in_data.norm.degen;
    end
  end

  // one quotient bit per stage, shifted in below the numerator bits
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [LW:0] r2 [3];
    logic [2:0]  qb;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i] = {st[k].rem[i], st[k].low[i][QW-1]};
        qb[i] = (r2[i] >= (LW+1)'(st[k].len));
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+2] <= 1'b0;
      end else if (en) begin
        vld[k+2] <= vld[k+1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          st[k+1].rem[i] <= qb[i] ? LW'(r2[i] - (LW+1)'(st[k].len)) : LW'(r2[i]);
          st[k+1].low[i] <= {st[k].low[i][QW-2:0], qb[i]};
        end
        st[k+1].len   <= st[k].len;
        st[k+1].neg   <= st[k].neg;
        st[k+1].degen <= st[k].degen;
      end
    end
  end

  logic signed [OW-1:0] comp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (st[QW].degen) begin
        comp[i] = '0;
      end else if (st[QW].neg[i]) begin
        comp[i] = -$signed(OW'(st[QW].low[i]));
      end else begin
        comp[i] = $signed(OW'(st[QW].low[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QW+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.normal_x   <= comp[0];
      out_data.normal_y   <= comp[1];
      out_data.normal_z   <= comp[2];
      out_data.degenerate <= st[QW].degen;
    end
  end

endmodule
